[rtl/core/lpss_pkg.sv]
package lpss_pkg;

    localparam int unsigned MAX_LEDS_DEF = 1024;

    localparam int unsigned LED_COUNT_W = 11;
    localparam int unsigned TICK_W      = 8;
    localparam int unsigned LATCH_W     = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned COLOR_W     = 3 * CHAN_W;
    localparam int unsigned BIT_IDX_W   = 5;
    localparam int unsigned IN_DATA_W   = 24;
    localparam int unsigned OUT_DATA_W  = 8;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(COLOR_W - 1);

    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 11'd8;
    localparam logic [TICK_W-1:0]      ZERO_HI_RST   = 8'd7;
    localparam logic [TICK_W-1:0]      ONE_HI_RST    = 8'd14;
    localparam logic [TICK_W-1:0]      PERIOD_RST    = 8'd40;
    localparam logic [LATCH_W-1:0]     LATCH_LOW_RST = 16'd1600;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HI    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } t_phase;

    typedef struct packed {
        logic [LED_COUNT_W-1:0] led_count;
        logic [TICK_W-1:0]      zero_hi;
        logic [TICK_W-1:0]      one_hi;
        logic [TICK_W-1:0]      period;
        logic [LATCH_W-1:0]     latch_low;
    } t_cfg;

    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic data_line;
    } t_result;

endpackage

[rtl/core/led_strip_pulse_serializer_top.sv]
// single-wire led strip driver, one request in gives one result out
// input stream: tuser[0] is the kind, 0 = one time tick, 1 = color request;
//   tdata carries red, green, blue, used only by a color request
// output stream: tdata carries data_line, busy_res, rejected; data_line is
//   the pin level for the time unit after the request
// every led gets the same color, red then green then blue, msb first; each
//   bit is high for the zero or one high time, low for the rest of the period,
//   then the line stays low for the latch time before the block goes idle
// a color request while busy is dropped and answered with rejected set
// the result sits in the output register from the cycle after acceptance
// one request per cycle unless the output stalls
// a stalled output holds its result and holds off s_axis_tready until taken
// reset: idle, line low, registers back to 8 leds, 7/14/40 ticks, 1600 latch
// configuration writes are registered and are meant for an idle block
module led_strip_pulse_serializer_top #(
    parameter int unsigned MAX_LEDS = lpss_pkg::MAX_LEDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [lpss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // data_line [0], busy_res [1], rejected [2], zeros above
    output logic [lpss_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [lpss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lpss_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    take;
    logic    [COLOR_W-1:0] color;

    assign take  = s_axis_tvalid && s_axis_tready;
    assign color = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    lpss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpss_seq #(
        .MAX_LEDS (MAX_LEDS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_take  (take),
        .i_req   (s_axis_tuser),
        .i_color (color),
        .o_res   (res)
    );

    lpss_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_res   (res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

[rtl/core/lpss_cfg.sv]
module lpss_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lpss_pkg::t_cfg                 o_cfg
);
    import lpss_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LED_COUNT: n_cfg.led_count = i_cfg_data[LED_COUNT_W-1:0];
                CFG_ZERO_HI:   n_cfg.zero_hi   = i_cfg_data[TICK_W-1:0];
                CFG_ONE_HI:    n_cfg.one_hi    = i_cfg_data[TICK_W-1:0];
                CFG_PERIOD:    n_cfg.period    = i_cfg_data[TICK_W-1:0];
                CFG_LATCH_LOW: n_cfg.latch_low = i_cfg_data[LATCH_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count <= LED_COUNT_RST;
            r_cfg.zero_hi   <= ZERO_HI_RST;
            r_cfg.one_hi    <= ONE_HI_RST;
            r_cfg.period    <= PERIOD_RST;
            r_cfg.latch_low <= LATCH_LOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/lpss_seq.sv]
module lpss_seq #(
    parameter int unsigned MAX_LEDS = lpss_pkg::MAX_LEDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpss_pkg::t_cfg               i_cfg,
    input  logic                         i_take,
    input  logic                         i_req,
    input  logic [lpss_pkg::COLOR_W-1:0] i_color,
    output lpss_pkg::t_result            o_res
);
    import lpss_pkg::*;

    localparam int unsigned IW = $clog2(MAX_LEDS + 1);
    localparam int unsigned CW = (IW > LED_COUNT_W) ? IW : LED_COUNT_W;

    t_phase               r_phase, n_phase;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [IW-1:0]        r_led, n_led;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [LATCH_W-1:0]   r_latch, n_latch;

    logic [CW-1:0]   eff_leds;
    logic [CW-1:0]   led_cnt_ext;
    logic            rej;
    logic            bit_val;
    logic [TICK_W-1:0] hi_ticks;

    assign led_cnt_ext = CW'(i_cfg.led_count);
    assign eff_leds    = (led_cnt_ext > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : led_cnt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_color <= '0;
            r_led   <= '0;
            r_bit   <= '0;
            r_tick  <= '0;
            r_latch <= '0;
        end else begin
            r_phase <= n_phase;
            r_color <= n_color;
            r_led   <= n_led;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_latch <= n_latch;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_color = r_color;
        n_led   = r_led;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_latch = r_latch;
        rej     = 1'b0;
        if (i_take) begin
            if (i_req) begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_color = i_color;
                    n_led   = '0;
                    n_bit   = '0;
                    n_tick  = '0;
                    if (eff_leds == '0) begin
                        n_phase = PH_LATCH;
                        n_latch = LATCH_W'(1);
                    end else begin
                        n_phase = PH_SEND;
                        n_latch = '0;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_SEND: begin
                        if ({1'b0, r_tick} + 9'd1 >= {1'b0, i_cfg.period}) begin
                            n_tick = '0;
                            if (r_bit >= LAST_BIT) begin
                                n_bit = '0;
                                n_led = r_led + IW'(1);
                                if (CW'(r_led) + CW'(1) >= eff_leds) begin
                                    n_phase = PH_LATCH;
                                    n_latch = LATCH_W'(1);
                                end
                            end else begin
                                n_bit = r_bit + BIT_IDX_W'(1);
                            end
                        end else begin
                            n_tick = r_tick + TICK_W'(1);
                        end
                    end
                    PH_LATCH: begin
                        if (r_latch >= i_cfg.latch_low) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_latch = r_latch + LATCH_W'(1);
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // msb of red goes first
    assign bit_val  = n_color[LAST_BIT - n_bit];
    assign hi_ticks = bit_val ? i_cfg.one_hi : i_cfg.zero_hi;

    assign o_res.data_line = (n_phase == PH_SEND) && (n_tick < hi_ticks);
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.rejected  = rej;

`ifndef SYNTH
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= LAST_BIT)
        else $error("bit index out of range");

    a_led_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEND) |-> (CW'(r_led) < eff_leds))
        else $error("led index past frame end while sending");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_req && r_phase == PH_IDLE) |=> (r_phase != PH_IDLE))
        else $error("accepted color request did not start a frame");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_take || (i_req && r_phase != PH_IDLE))
            |=> ($stable(r_phase) && $stable(r_tick) && $stable(r_bit)))
        else $error("state moved without an advancing request");
`endif

endmodule

[rtl/core/lpss_out.sv]
module lpss_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  lpss_pkg::t_result                  i_res,
    output logic                               o_ready,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lpss_pkg::OUT_DATA_W-1:0]    o_data
);
    import lpss_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(OUT_DATA_W - 3){1'b0}}, r_res};

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpss_pkg::*;

    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PRINT_LIMIT   = 40;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    class strip_waveform_tracker;
        t_cfg             cfg;
        logic [COLOR_W-1:0] color;
        int unsigned      led_idx;
        int unsigned      bit_idx;
        int unsigned      tick;
        int unsigned      latch_cnt;
        t_phase           phase;
        t_result          expected_levels[$];
        int unsigned      mismatches;
        int unsigned      seen;

        function new();
            cfg.led_count = LED_COUNT_RST;
            cfg.zero_hi   = ZERO_HI_RST;
            cfg.one_hi    = ONE_HI_RST;
            cfg.period    = PERIOD_RST;
            cfg.latch_low = LATCH_LOW_RST;
            color      = '0;
            led_idx    = 0;
            bit_idx    = 0;
            tick       = 0;
            latch_cnt  = 0;
            phase      = PH_IDLE;
            mismatches = 0;
            seen       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LED_COUNT: cfg.led_count = value[LED_COUNT_W-1:0];
                CFG_ZERO_HI:   cfg.zero_hi   = value[TICK_W-1:0];
                CFG_ONE_HI:    cfg.one_hi    = value[TICK_W-1:0];
                CFG_PERIOD:    cfg.period    = value[TICK_W-1:0];
                CFG_LATCH_LOW: cfg.latch_low = value[LATCH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_leds();
            return (cfg.led_count > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(cfg.led_count);
        endfunction

        function logic pin_level();
            logic      bit_val;
            int unsigned hi;
            if (phase != PH_SEND) begin
                return 1'b0;
            end
            bit_val = color[COLOR_W - 1 - bit_idx];
            hi = bit_val ? cfg.one_hi : cfg.zero_hi;
            return (tick < hi);
        endfunction

        function void advance();
            if (phase == PH_SEND) begin
                if (tick + 1 >= cfg.period) begin
                    tick = 0;
                    if (bit_idx >= COLOR_W - 1) begin
                        bit_idx = 0;
                        led_idx++;
                        if (led_idx >= frame_leds()) begin
                            phase     = PH_LATCH;
                            latch_cnt = 1;
                        end
                    end else begin
                        bit_idx++;
                    end
                end else begin
                    tick++;
                end
            end else if (phase == PH_LATCH) begin
                if (latch_cnt >= cfg.latch_low) begin
                    phase = PH_IDLE;
                end else begin
                    latch_cnt++;
                end
            end
        endfunction

        function void take_request(logic kind, logic [IN_DATA_W-1:0] rgb);
            t_result res;
            res = '0;
            if (kind == KIND_COLOR) begin
                if (phase != PH_IDLE) begin
                    res.rejected = 1'b1;
                end else begin
                    color     = {rgb[7:0], rgb[15:8], rgb[23:16]};
                    led_idx   = 0;
                    bit_idx   = 0;
                    tick      = 0;
                    latch_cnt = 0;
                    if (frame_leds() == 0) begin
                        phase     = PH_LATCH;
                        latch_cnt = 1;
                    end else begin
                        phase = PH_SEND;
                    end
                end
            end else begin
                advance();
            end
            res.data_line = pin_level();
            res.busy_res  = (phase != PH_IDLE);
            expected_levels.push_back(res);
        endfunction

        task report(string what);
            if (mismatches < PRINT_LIMIT) begin
                $display("%0t: result %0d: %s", $time, seen, what);
            end
            mismatches++;
        endtask

        task check_level(logic [OUT_DATA_W-1:0] word);
            t_result want;
            t_result got;
            seen++;
            if (expected_levels.size() == 0) begin
                report($sformatf("unexpected result %h", word));
                return;
            end
            want = expected_levels.pop_front();
            got  = word[2:0];
            if (got.data_line !== want.data_line) begin
                report($sformatf("data_line %b, want %b", got.data_line, want.data_line));
            end
            if (got.busy_res !== want.busy_res) begin
                report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
            end
            if (got.rejected !== want.rejected) begin
                report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
            end
            if (word[OUT_DATA_W-1:3] !== '0) begin
                report($sformatf("padding bits %b not zero", word[OUT_DATA_W-1:3]));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    strip_waveform_tracker board;

    led_strip_pulse_serializer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // handshakes are sampled at the falling edge, where every input is settled
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_level(m_axis_tdata);
        end
    end

    always @(negedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] rgb);
        logic hit;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= rgb;
        do begin
            @(negedge i_clk);
            hit = s_axis_tready;
            @(posedge i_clk);
        end while (!hit);
        board.take_request(kind, rgb);
    endtask

    task automatic ticks_until(input t_phase target);
        while (board.phase != target) begin
            send_item(KIND_TICK, IN_DATA_W'($urandom()));
        end
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (board.expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.write_reg(idx, value);
    endtask

    task automatic write_all(input logic [LED_COUNT_W-1:0] leds, input logic [TICK_W-1:0] zero_hi,
                             input logic [TICK_W-1:0] one_hi, input logic [TICK_W-1:0] period,
                             input logic [LATCH_W-1:0] latch_low);
        put_reg(CFG_LED_COUNT, CFG_DATA_W'(leds));
        put_reg(CFG_ZERO_HI, CFG_DATA_W'(zero_hi));
        put_reg(CFG_ONE_HI, CFG_DATA_W'(one_hi));
        put_reg(CFG_PERIOD, CFG_DATA_W'(period));
        put_reg(CFG_LATCH_LOW, CFG_DATA_W'(latch_low));
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 57; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default:       begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    // random color requests and ticks, including color requests that land while busy
    task automatic random_items(input int unsigned count, input bit hold_mid);
        logic kind;
        for (int unsigned n = 0; n < count; n++) begin
            if (hold_mid && n == count / 2) begin
                wait_results();
            end
            if (board.phase == PH_IDLE) begin
                kind = ($urandom_range(0, 9) < 8) ? KIND_COLOR : KIND_TICK;
            end else begin
                kind = ($urandom_range(0, 15) == 0) ? KIND_COLOR : KIND_TICK;
            end
            send_item(kind, IN_DATA_W'($urandom()));
        end
    endtask

    initial begin
        board = new();
        set_idling(IDLE_NONE);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick, then requests while sending and while latching
        send_item(KIND_TICK, 24'h000000);
        settle();
        write_all(11'd1, 8'd1, 8'd2, 8'd3, 16'd2);
        send_item(KIND_COLOR, {8'hA5, 8'h00, 8'hFF});
        send_item(KIND_COLOR, 24'hFFFFFF);
        send_item(KIND_TICK, 24'hFFFFFF);
        ticks_until(PH_LATCH);
        send_item(KIND_COLOR, 24'h123456);
        ticks_until(PH_IDLE);
        send_item(KIND_TICK, 24'h000000);
        settle();

        // no leds: straight into the latch, zero latch time acts as one
        write_all(11'd0, 8'd3, 8'd5, 8'd4, 16'd0);
        send_item(KIND_COLOR, 24'hC33CFF);
        send_item(KIND_COLOR, 24'h00FF00);
        ticks_until(PH_IDLE);
        send_item(KIND_TICK, 24'h000000);
        settle();

        // one tick per bit, zero bits low throughout, one bits high throughout
        write_all(11'd1, 8'd0, 8'd255, 8'd1, 16'd2);
        send_item(KIND_COLOR, 24'h5AF00F);
        ticks_until(PH_IDLE);
        settle();

        // zero bit period
        write_all(11'd1, 8'd1, 8'd2, 8'd0, 16'd1);
        send_item(KIND_COLOR, 24'h000000);
        ticks_until(PH_IDLE);
        send_item(KIND_COLOR, 24'hFFFFFF);
        ticks_until(PH_IDLE);
        settle();

        // high time past the period, longer latch
        write_all(11'd1, 8'd255, 8'd1, 8'd2, 16'd20);
        send_item(KIND_COLOR, 24'h33AA55);
        ticks_until(PH_IDLE);
        settle();

        for (int p = 0; p < 4; p++) begin
            write_all($urandom_range(0, 9) == 0 ? 11'd0 : 11'd1,
                      TICK_W'($urandom_range(0, 4)), TICK_W'($urandom_range(0, 4)),
                      TICK_W'($urandom_range(0, 3)), LATCH_W'($urandom_range(0, 5)));
            set_idling(t_idle_mode'(p % 4));
            random_items(20, p == 2);
            ticks_until(PH_IDLE);
            settle();
        end

        if (board.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
